@@ hdl/lkvc_pkg.sv @@
// lkvc_pkg: types, codes and constants shared by the lru key-value cache
// no dependencies; imported by lkvc_cell and lru_key_value_cache_unit
`default_nettype none

package lkvc_pkg;

  localparam int LKVC_ENTRIES = 64;
  localparam int KEY_W        = 64;
  localparam int VAL_W        = 31;
  localparam int CAP_W        = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_RSVD   = 2'd3;

  typedef enum logic [2:0] {
    ST_HIT         = 3'd0,
    ST_FILLED      = 3'd1,
    ST_FILL_FAILED = 3'd2,
    ST_REMOVED     = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_CLEARED     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } state_t;

  typedef enum logic [2:0] {
    UPD_HOLD,
    UPD_HIT,
    UPD_INSERT,
    UPD_REMOVE,
    UPD_CLEAR
  } upd_op_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] fill_value;
    logic             fill_ok;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [VAL_W-1:0] evicted_value;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    entry_t entry;
    logic   tail;
  } cell_link_t;

  typedef struct packed {
    logic             cmp_en;
    upd_op_t          op;
    logic             evict;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/lkvc_cell.sv @@
// lkvc_cell: one position of the recency-ordered row (position 0 is most recent)
// holds one entry, compares it with the request key, shifts to or from its neighbours
// depends on lkvc_pkg
`default_nettype none

module lkvc_cell (
  input  wire                    clk,
  input  wire                    rst_n,
  input  lkvc_pkg::cell_cmd_t    cmd,
  input  lkvc_pkg::cell_link_t   prev_link,
  input  lkvc_pkg::entry_t       next_entry,
  input  wire                    above_in,
  output logic                   above_out,
  output lkvc_pkg::cell_link_t   link_out,
  output logic                   match
);
  import lkvc_pkg::*;

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic             match_r, match_nxt;

  always_comb begin
    match_nxt = match_r;
    if (cmd.cmp_en) begin
      match_nxt = valid_r && (key_r == cmd.key);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    unique case (cmd.op)
      UPD_CLEAR: begin
        valid_nxt = 1'b0;
      end
      UPD_HIT: begin
        if (!above_in) begin
          valid_nxt = prev_link.entry.valid;
          key_nxt   = prev_link.entry.key;
          value_nxt = prev_link.entry.value;
        end
      end
      UPD_INSERT: begin
        valid_nxt = prev_link.entry.valid && !(cmd.evict && prev_link.tail);
        key_nxt   = prev_link.entry.key;
        value_nxt = prev_link.entry.value;
      end
      UPD_REMOVE: begin
        if (above_in || match_r) begin
          valid_nxt = next_entry.valid;
          key_nxt   = next_entry.key;
          value_nxt = next_entry.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign above_out           = above_in || match_r;
  assign match               = match_r;
  assign link_out.entry.valid = valid_r;
  assign link_out.entry.key   = key_r;
  assign link_out.entry.value = value_r;
  assign link_out.tail        = valid_r && !next_entry.valid;

endmodule

`default_nettype wire

@@ hdl/lru_key_value_cache_unit.sv @@
// each request passes a compare state, then an update state (shift and result register);
// the update waits while an earlier result is still held at the output; a new beat is
// taken in the cycle the shift of the cell row completes
// reset (synchronous, active low) clears all valid bits, the live count and the
// output valid flag at once; capacity returns to 64; no clearing pass
`default_nettype none

module lru_key_value_cache_unit #(
  parameter int ENTRIES = lkvc_pkg::LKVC_ENTRIES
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  lkvc_pkg::req_t           in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output lkvc_pkg::rsp_t           out_data,
  input  wire                      cfg_we,
  input  wire [lkvc_pkg::CAP_W-1:0] cfg_wdata
);
  import lkvc_pkg::*;

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  state_t            state_r, state_nxt;
  req_t              req_r;
  logic [CAP_W-1:0]  capacity_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_data_r, out_data_nxt;

  cell_cmd_t         cmd;
  cell_link_t        head_link;
  cell_link_t        link [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES:0]   above;

  logic              in_fire, out_free, upd_done, hit, evict, full;
  logic [VAL_W-1:0]  hit_value;
  logic [KEY_W-1:0]  ev_key;
  logic [VAL_W-1:0]  ev_value;

  assign above[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_link_t prev_l;
    entry_t     next_e;
    if (i == 0) begin : g_head
      assign prev_l = head_link;
    end else begin : g_mid
      assign prev_l = link[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = link[i+1].entry;
    end
    lkvc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_link  (prev_l),
      .next_entry (next_e),
      .above_in   (above[i]),
      .above_out  (above[i+1]),
      .link_out   (link[i]),
      .match      (match_vec[i])
    );
    assign valid_vec[i] = link[i].entry.valid;
  end

  assign hit      = above[ENTRIES];
  assign full     = valid_vec[ENTRIES-1];
  assign out_free = !out_valid_r || out_ready;
  assign upd_done = out_free || (req_r.req_type == REQ_RSVD);
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_UPDATE) && upd_done);
  assign in_fire  = in_valid && in_ready;
  assign evict    = (count_r != '0) && (full || (CMPW'(count_r) >= CMPW'(capacity_r)));

  always_comb begin
    hit_value = '0;
    ev_key    = '0;
    ev_value  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_value = hit_value | link[i].entry.value;
      end
      if (link[i].tail) begin
        ev_key   = ev_key | link[i].entry.key;
        ev_value = ev_value | link[i].entry.value;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (upd_done) state_nxt = in_fire ? S_MATCH : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell row command
  always_comb begin
    cmd.cmp_en = (state_r == S_MATCH);
    cmd.key    = req_r.key;
    cmd.evict  = evict;
    cmd.op     = UPD_HOLD;
    if ((state_r == S_UPDATE) && upd_done) begin
      unique case (req_r.req_type)
        REQ_LOOKUP: begin
          if (hit) cmd.op = UPD_HIT;
          else if (req_r.fill_ok) cmd.op = UPD_INSERT;
        end
        REQ_REMOVE: begin
          if (hit) cmd.op = UPD_REMOVE;
        end
        REQ_CLEAR: cmd.op = UPD_CLEAR;
        default: cmd.op = UPD_HOLD;
      endcase
    end
    head_link.entry.valid = 1'b1;
    head_link.entry.key   = req_r.key;
    head_link.entry.value = hit ? hit_value : req_r.fill_value;
    head_link.tail        = 1'b0;
  end

  // live count and result
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (cmd.op)
      UPD_INSERT: if (!evict) count_nxt = count_r + CW'(1);
      UPD_REMOVE: count_nxt = count_r - CW'(1);
      UPD_CLEAR:  count_nxt = '0;
      default: begin
      end
    endcase
    if ((state_r == S_UPDATE) && upd_done && (req_r.req_type != REQ_RSVD)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      unique case (req_r.req_type)
        REQ_LOOKUP: begin
          if (hit) begin
            out_data_nxt.status = ST_HIT;
            out_data_nxt.value  = hit_value;
          end else if (req_r.fill_ok) begin
            out_data_nxt.status = ST_FILLED;
            out_data_nxt.value  = req_r.fill_value;
            if (evict && (count_r != '0)) begin
              out_data_nxt.evicted       = 1'b1;
              out_data_nxt.evicted_key   = ev_key;
              out_data_nxt.evicted_value = ev_value;
            end
          end else begin
            out_data_nxt.status = ST_FILL_FAILED;
          end
        end
        REQ_REMOVE: out_data_nxt.status = hit ? ST_REMOVED : ST_NOT_FOUND;
        default:    out_data_nxt.status = ST_CLEARED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      capacity_r  <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) capacity_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) req_r <= in_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= ENTRIES)
    else $error("live count above table size");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("live count disagrees with valid cells");

  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |-> $onehot0(match_vec))
    else $error("key held in more than one cell");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_UPDATE) && upd_done && (req_r.req_type != REQ_RSVD)) |=> out_valid_r)
    else $error("completed request gave no result beat");

  a_accept_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_MATCH))
    else $error("accepted beat not compared next cycle");

endmodule

`default_nettype wire
